@@ rtl/bta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap tag allocator package
// Sizes, codes, payload types and the find-first-zero helper shared by the
// allocator and its checker.
// ----------------------------------------------------------------------------
package bta_pkg;

    // Bitmap geometry
    localparam int WORD_BITS_LOG2 = 5;
    localparam int NUM_WORDS      = 2048;
    localparam int WORD_BITS      = 1 << WORD_BITS_LOG2;
    localparam int ADDR_W         = $clog2(NUM_WORDS);
    localparam int TAG_W          = 16;

    typedef logic [WORD_BITS-1:0]      t_word;
    typedef logic [ADDR_W-1:0]         t_addr;
    typedef logic [WORD_BITS_LOG2-1:0] t_bit_idx;

    localparam t_addr LAST_ADDR = ADDR_W'(NUM_WORDS - 1);
    localparam t_word WORD_FULL = '1;
    localparam t_word WORD_LOW  = t_word'(1);
    localparam t_word WORD_TOP  = t_word'(1) << (WORD_BITS - 1);

    // Commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_RESERVED  = 2'd2;

    typedef struct packed {
        logic             command;
        logic [TAG_W-1:0] tag_to_free;
    } t_in_item;

    typedef struct packed {
        logic [TAG_W-1:0] granted_tag;
        logic [1:0]       status;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_OUT
    } t_state;

    // Lowest clear bit of a word (don't care when the word is full)
    function automatic t_bit_idx find_first_zero(input t_word word);
        t_bit_idx idx;
        idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!word[b]) begin
                idx = t_bit_idx'(b);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/bitmap_tag_allocator.sv @@
`timescale 1ns / 1ps
// Allocate: one bitmap word read per cycle until a word with a clear bit is found
//   or the last word has been checked (exhausted).
// Free: read-modify-write of one word; a reserved tag returns without the write.
//   An output stall holds the finished result in ST_OUT.
// One item at a time; the next transfer is taken the cycle after the result loads.
// Reset: a clearing pass writes all NUM_WORDS (2048) words, one per cycle, input stalled.
// ----------------------------------------------------------------------------
// Bitmap tag allocator
// Hands out the lowest free 16-bit tag from a one-bit-per-tag bitmap and
// takes tags back; tag 0 and the highest tag are reserved.
// ----------------------------------------------------------------------------
module bitmap_tag_allocator
    import bta_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_state    r_state, n_state;
    t_addr     r_addr, n_addr;
    t_addr     r_chk_addr, n_chk_addr;
    logic      r_chk_valid, n_chk_valid;
    logic [TAG_W-1:0] r_tag, n_tag;
    t_out_item r_res, n_res;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item, n_out_item;

    // Bitmap storage
    t_word r_mem [NUM_WORDS];
    t_word r_rd_data;
    logic  mem_we;
    t_addr mem_waddr;
    t_word mem_wdata;
    t_addr mem_raddr;

    // Free-side decode of the held tag
    logic [31:0] free_word;
    t_bit_idx    free_bit;
    logic        free_reserved;
    logic        free_in_range;
    t_addr       free_addr;

    // Scan-side find-first-zero
    t_bit_idx    ffz_bit;
    logic [31:0] grant_tag;

    assign free_word     = 32'(r_tag >> WORD_BITS_LOG2);
    assign free_bit      = r_tag[WORD_BITS_LOG2-1:0];
    assign free_addr     = free_word[ADDR_W-1:0];
    assign free_in_range = free_word < 32'(NUM_WORDS);
    assign free_reserved = (r_tag == '0) ||
                           ((free_word == 32'(NUM_WORDS - 1)) && (free_bit == '1));

    assign ffz_bit   = find_first_zero(r_rd_data);
    assign grant_tag = 32'({r_chk_addr, ffz_bit});

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_chk_addr <= n_chk_addr;
        r_tag      <= n_tag;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_chk_addr  = r_chk_addr;
        n_chk_valid = r_chk_valid;
        n_tag       = r_tag;
        n_res       = r_res;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_waddr   = r_chk_addr;
        mem_wdata   = r_rd_data;
        mem_raddr   = r_addr;

        unique case (r_state)
            // Write reset contents, one word per cycle
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = ((r_addr == '0) ? WORD_LOW : '0) |
                            ((r_addr == LAST_ADDR) ? WORD_TOP : '0);
                n_addr    = r_addr + t_addr'(1);
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            // Take a transfer
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_tag       = i_in_item.tag_to_free;
                    n_addr      = '0;
                    n_chk_valid = 1'b0;
                    n_state     = (i_in_item.command == CMD_FREE) ? ST_FREE_RD : ST_SCAN;
                end
            end
            // Issue one read per cycle, check the word read last cycle
            ST_SCAN: begin
                n_addr      = r_addr + t_addr'(1);
                n_chk_addr  = r_addr;
                n_chk_valid = 1'b1;
                if (r_chk_valid) begin
                    if (r_rd_data != WORD_FULL) begin
                        mem_we          = 1'b1;
                        mem_wdata       = r_rd_data | (WORD_LOW << ffz_bit);
                        n_res.granted_tag = grant_tag[TAG_W-1:0];
                        n_res.status    = STATUS_OK;
                        n_state         = ST_OUT;
                    end else if (r_chk_addr == LAST_ADDR) begin
                        n_res.granted_tag = '0;
                        n_res.status    = STATUS_EXHAUSTED;
                        n_state         = ST_OUT;
                    end
                end
            end
            // Screen the tag and read its word
            ST_FREE_RD: begin
                mem_raddr         = free_addr;
                n_chk_addr        = free_addr;
                n_res.granted_tag = '0;
                if (free_reserved) begin
                    n_res.status = STATUS_RESERVED;
                    n_state      = ST_OUT;
                end else if (!free_in_range) begin
                    n_res.status = STATUS_OK;
                    n_state      = ST_OUT;
                end else begin
                    n_res.status = STATUS_OK;
                    n_state      = ST_FREE_WR;
                end
            end
            // Clear the tag's bit
            ST_FREE_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rd_data & ~(WORD_LOW << free_bit);
                n_state   = ST_OUT;
            end
            // Hand the result to the output register once it is free
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_item  = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/bta_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap tag allocator checker
// Port-level assertions on handshake and result encoding, bound to the top.
// ----------------------------------------------------------------------------
module bta_checker
    import bta_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed or dropped");

    // Stall after each input transfer while the item is worked
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second transfer taken while busy");

    // Only a successful allocate carries a tag
    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != STATUS_OK)) |-> (o_out_item.granted_tag == '0))
        else $error("tag returned with failing status");

    // Status stays within its codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status == STATUS_OK ||
                         o_out_item.status == STATUS_EXHAUSTED ||
                         o_out_item.status == STATUS_RESERVED))
        else $error("undefined status code");

endmodule

bind bitmap_tag_allocator bta_checker u_bta_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
